/* src/multi_channel_relay_duty_timer_core_assert.svh */
// Assertion macros used by the mcrdt_checker file.
`ifndef MULTI_CHANNEL_RELAY_DUTY_TIMER_CORE_ASSERT_SVH
`define MULTI_CHANNEL_RELAY_DUTY_TIMER_CORE_ASSERT_SVH

// same-cycle implication
`define MCRDT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define MCRDT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/mcrdt_pkg.sv */
package mcrdt_pkg;

  localparam int DUTY_BITS  = 7;
  localparam int COUNT_BITS = 26;
  localparam int MS_BITS    = 8;
  localparam int IN_BITS    = 8;

  localparam logic [DUTY_BITS-1:0] DUTY_MAX = 7'd100;

  // output word: levels then changed mask, padded to whole bytes
  function automatic int out_bits(input int channels);
    return ((2 * channels + 7) >> 3) << 3;
  endfunction

endpackage

/* src/multi_channel_relay_duty_timer_core.sv */
// Channel  | Signals                          | Word
// ---------+----------------------------------+------------------------------------
// input    | s_tvalid s_tready s_tdata        | ms_passed
// output   | m_tvalid m_tready m_tdata        | relay_levels, changed_mask
// config   | psel penable pwrite paddr pwdata | channel settings, then on_level
//
// One word a cycle while the output does not stall: an input register, then
// one pass through the per-channel add, saturate, multiply and compare into the
// result register. Reset clears counters to expired, levels to off and channel
// settings to zero, and sets on_level. An output stall holds the result; the input
// register still fills behind it.
module multi_channel_relay_duty_timer_core
  import mcrdt_pkg::*;
#(
  parameter int CHANNELS    = 4,
  parameter int PERIOD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [IN_BITS-1:0]            s_tdata,   // [7:0] ms_passed
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [out_bits(CHANNELS)-1:0] m_tdata,   // relay_levels, changed_mask, zero pad
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [$clog2(4*(CHANNELS+1))-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int AW = $clog2(4 * (CHANNELS + 1));
  localparam int IW = AW - 2;
  localparam int SW = DUTY_BITS + PERIOD_BITS;
  localparam int PW = DUTY_BITS + PERIOD_BITS;
  localparam int LW = PW + 4;
  localparam int CW = (COUNT_BITS > LW) ? COUNT_BITS : LW;
  localparam int OW = out_bits(CHANNELS);
  localparam logic [IW-1:0] ON_LEVEL_IDX = IW'(CHANNELS);

  logic [SW-1:0]         setting [CHANNELS];
  logic                  on_level;
  logic [CHANNELS-1:0]   level;
  logic [COUNT_BITS-1:0] elapsed [CHANNELS];
  logic [COUNT_BITS-1:0] cnt     [CHANNELS];
  logic [CHANNELS-1:0]   hit;

  logic                  in_valid;
  logic [MS_BITS-1:0]    in_ms;
  logic                  out_valid;
  logic [CHANNELS-1:0]   out_levels;
  logic [CHANNELS-1:0]   out_changed;

  logic                  out_free;
  logic                  advance;
  logic                  wr;
  logic [IW-1:0]         idx;

  assign pready   = 1'b1;
  assign wr       = psel & penable & pwrite;
  assign idx      = paddr[AW-1:2];

  assign out_free = ~out_valid | m_tready;
  assign advance  = in_valid & out_free;
  assign s_tready = ~in_valid | out_free;
  assign m_tvalid = out_valid;
  assign m_tdata  = OW'({out_changed, out_levels});

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      on_level <= 1'b1;
      for (int i = 0; i < CHANNELS; i++) setting[i] <= '0;
    end else if (wr) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (idx == IW'(i)) setting[i] <= pwdata[SW-1:0];
      end
      if (idx == ON_LEVEL_IDX) on_level <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (idx == IW'(i)) prdata = 32'(setting[i]);
    end
    if (idx == ON_LEVEL_IDX) prdata = 32'(on_level);
  end

  // per-channel phase compare
  for (genvar g = 0; g < CHANNELS; g++) begin : g_ch
    logic [DUTY_BITS-1:0]   duty_raw;
    logic [DUTY_BITS-1:0]   duty;
    logic [PERIOD_BITS-1:0] period;
    logic [DUTY_BITS-1:0]   pct;
    logic [PW-1:0]          prod;
    logic [LW-1:0]          limit;
    logic [COUNT_BITS:0]    sum;

    assign duty_raw = setting[g][DUTY_BITS-1:0];
    assign duty     = (duty_raw > DUTY_MAX) ? DUTY_MAX : duty_raw;
    assign period   = setting[g][SW-1:DUTY_BITS];
    assign pct      = (level[g] == on_level) ? duty : DUTY_MAX - duty;
    assign prod     = PW'(pct) * PW'(period);
    // x10 as x8 + x2
    assign limit    = (LW'(prod) << 3) + (LW'(prod) << 1);
    assign sum      = {1'b0, elapsed[g]} + (COUNT_BITS+1)'(in_ms);
    assign cnt[g]   = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
    assign hit[g]   = (duty != '0) && (CW'(cnt[g]) >= CW'(limit));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
      for (int i = 0; i < CHANNELS; i++) elapsed[i] <= '1;
    end else if (advance) begin
      level <= level ^ hit;
      for (int i = 0; i < CHANNELS; i++) elapsed[i] <= hit[i] ? '0 : cnt[i];
    end
  end

  // input and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) in_valid <= s_tvalid;
      if (out_free) out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) in_ms <= s_tdata[MS_BITS-1:0];
    if (advance) begin
      out_levels  <= level ^ hit;
      out_changed <= hit;
    end
  end

endmodule

/* src/mcrdt_checker.sv */
`include "multi_channel_relay_duty_timer_core_assert.svh"

module mcrdt_checker
  import mcrdt_pkg::*;
#(
  parameter int CHANNELS = 4
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [out_bits(CHANNELS)-1:0] m_tdata
);

  logic [CHANNELS-1:0] last_levels;
  logic [CHANNELS-1:0] word_levels;
  logic [CHANNELS-1:0] word_changed;

  assign word_levels  = m_tdata[CHANNELS-1:0];
  assign word_changed = m_tdata[2*CHANNELS-1:CHANNELS];

  // levels of the last word taken; all off after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      last_levels <= '0;
    end else if (m_tvalid && m_tready) begin
      last_levels <= word_levels;
    end
  end

  `MCRDT_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // input side only backs up behind a stalled output word
  `MCRDT_ASSERT_NOW(a_in_stall, clk, rst, !s_tready, m_tvalid && !m_tready)
  // a level moves only where the word marks a toggle
  `MCRDT_ASSERT_NOW(a_toggle, clk, rst, m_tvalid, word_levels == (last_levels ^ word_changed))

endmodule

bind multi_channel_relay_duty_timer_core mcrdt_checker #(.CHANNELS(CHANNELS)) u_mcrdt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* tb/sv/relay_timer_tb_pkg.sv */
`timescale 1ns / 1ps
package relay_timer_tb_pkg;

  // register index on the config port, byte address = 4 * index
  typedef enum int {
    REG_CH0      = 0,
    REG_CH1      = 1,
    REG_CH2      = 2,
    REG_CH3      = 3,
    REG_ON_LEVEL = 4,
    REG_UNUSED   = 5
  } reg_index_e;

  // output word as it sits in m_tdata
  typedef struct packed {
    logic [3:0] changed;
    logic [3:0] levels;
  } relay_word_t;

endpackage

/* tb/sv/relay_timer_checker.sv */
`timescale 1ns / 1ps
module relay_timer_checker
  import mcrdt_pkg::*;
  import relay_timer_tb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [IN_BITS-1:0] s_tdata,   // [7:0] ms_passed
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [7:0]         m_tdata,   // [3:0] relay_levels, [7:4] changed_mask
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 mismatches,
  output int                 pending,
  output int                 words_checked,
  output int                 toggles_seen
);

  localparam int NCH = 4;

  logic [22:0]           ch_setting [NCH];
  logic                  on_lvl;
  logic                  drive_lvl  [NCH];
  logic [COUNT_BITS-1:0] elapsed_ms [NCH];
  relay_word_t           due_words [$];
  int                    fail_cnt;
  int                    checked_cnt;
  int                    toggle_cnt;

  task automatic advance_timers(input logic [MS_BITS-1:0] ms, output relay_word_t w);
    logic [DUTY_BITS-1:0] duty;
    logic [DUTY_BITS-1:0] pct;
    logic [15:0]          period;
    logic [COUNT_BITS:0]  sum;
    longint unsigned      span;
    int                   ch;
    w = '0;
    for (ch = 0; ch < NCH; ch++) begin
      duty   = (ch_setting[ch][6:0] > DUTY_MAX) ? DUTY_MAX : ch_setting[ch][6:0];
      period = ch_setting[ch][22:7];
      sum    = {1'b0, elapsed_ms[ch]} + ms;
      elapsed_ms[ch] = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
      if (duty != 0) begin
        pct  = (drive_lvl[ch] == on_lvl) ? duty : DUTY_MAX - duty;
        span = pct;
        span = span * period * 10;
        if (elapsed_ms[ch] >= span) begin
          drive_lvl[ch]  = ~drive_lvl[ch];
          elapsed_ms[ch] = '0;
          w.changed[ch]  = 1'b1;
          toggle_cnt++;
        end
      end
      w.levels[ch] = drive_lvl[ch];
    end
  endtask

  always @(posedge clk) begin
    relay_word_t exp_w;
    relay_word_t got_w;
    int idx;
    if (rst) begin
      on_lvl = 1'b1;
      for (idx = 0; idx < NCH; idx++) begin
        ch_setting[idx] = '0;
        drive_lvl[idx]  = 1'b0;
        elapsed_ms[idx] = '1;
      end
      due_words.delete();
      fail_cnt    = 0;
      checked_cnt = 0;
      toggle_cnt  = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        idx = int'(paddr) >> 2;
        if (idx < int'(REG_ON_LEVEL))
          ch_setting[idx] = pwdata[22:0];
        else if (idx == int'(REG_ON_LEVEL))
          on_lvl = pwdata[0];
      end
      if (m_tvalid && m_tready) begin
        got_w = relay_word_t'(m_tdata);
        if (due_words.size() == 0) begin
          $error("result word %h with nothing expected", m_tdata);
          fail_cnt++;
        end else begin
          exp_w = due_words.pop_front();
          if (got_w.levels !== exp_w.levels) begin
            $error("relay_levels: expected %h, actual %h", exp_w.levels, got_w.levels);
            fail_cnt++;
          end
          if (got_w.changed !== exp_w.changed) begin
            $error("changed_mask: expected %h, actual %h", exp_w.changed, got_w.changed);
            fail_cnt++;
          end
          checked_cnt++;
        end
      end
      if (s_tvalid && s_tready) begin
        advance_timers(s_tdata[MS_BITS-1:0], exp_w);
        due_words.push_back(exp_w);
      end
    end
    // published with nonblocking writes so the stimulus side sees a settled count
    mismatches    <= fail_cnt;
    pending       <= due_words.size();
    words_checked <= checked_cnt;
    toggles_seen  <= toggle_cnt;
  end

endmodule

/* tb/sv/tb_multi_channel_relay_duty_timer_core.sv */
`timescale 1ns / 1ps
module tb_multi_channel_relay_duty_timer_core;
  import mcrdt_pkg::*;
  import relay_timer_tb_pkg::*;

  localparam int HOLD_OFF_CYCLES = 60;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;   // [7:0] ms_passed
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;         // [3:0] relay_levels, [7:4] changed_mask
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [4:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int pending;
  int words_checked;
  int toggles_seen;
  int sent_words   = 0;
  int hold_asked   = 0;
  int hold_started = 0;

  always #5 clk = ~clk;

  multi_channel_relay_duty_timer_core #(
    .CHANNELS    (4),
    .PERIOD_BITS (16)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  relay_timer_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .mismatches    (mismatches),
    .pending       (pending),
    .words_checked (words_checked),
    .toggles_seen  (toggles_seen)
  );

  function automatic logic [31:0] setting_word(input logic [6:0] duty, input logic [15:0] period);
    return {9'd0, period, duty};
  endfunction

  function automatic logic [31:0] random_setting();
    logic [6:0]  duty;
    logic [15:0] period;
    case ($urandom_range(0, 7))
      0:       duty = 7'd0;
      1:       duty = 7'd1;
      2:       duty = 7'd100;
      3:       duty = 7'($urandom_range(101, 127));
      default: duty = 7'($urandom_range(1, 99));
    endcase
    // short periods keep the toggles coming; the odd wide one exercises the upper bits
    case ($urandom_range(0, 9))
      0:       period = 16'd0;
      1:       period = 16'hFFFF;
      2:       period = 16'($urandom_range(0, 65535));
      default: period = 16'($urandom_range(1, 3));
    endcase
    return setting_word(duty, period);
  endfunction

  function automatic logic [7:0] random_ms();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // back-to-back writes keep psel high; the last one of a group releases the bus
  task automatic write_reg(input reg_index_e idx, input logic [31:0] val, input bit last);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(int'(idx) * 4);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (last) begin
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
    end
  endtask

  task automatic send_ms(input logic [7:0] ms, input int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ms;
    do @(posedge clk); while (!s_tready);
    sent_words++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // result side: random ready pattern, plus a long hold-off on request
  initial begin : result_sink
    int  run;
    int  r;
    logic rdy;
    forever begin
      r = $urandom_range(0, 99);
      if (hold_asked != hold_started) begin
        hold_started = hold_asked;
        rdy = 1'b0;
        run = HOLD_OFF_CYCLES;
      end else if (r < 10) begin
        rdy = 1'b1;
        run = $urandom_range(20, 60);
      end else if (r < 65) begin
        rdy = 1'b1;
        run = $urandom_range(1, 6);
      end else if (r < 93) begin
        rdy = 1'b0;
        run = $urandom_range(1, 3);
      end else begin
        rdy = 1'b0;
        run = $urandom_range(8, 25);
      end
      while (run > 0 && (rdy == 1'b0 || hold_asked == hold_started)) begin
        m_tready <= rdy;
        @(posedge clk);
        run--;
      end
    end
  end

  initial begin : stimulus
    logic [7:0] opening_ms [12];
    int ph;
    int ch;
    int k;
    int n;
    int gap;
    opening_ms = '{8'd0, 8'd255, 8'd255, 8'd255, 8'd254, 8'd1,
                   8'd128, 8'd0, 8'd255, 8'd127, 8'd64, 8'd255};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (rst) @(posedge clk);

    // reset settings: every channel idle, nothing toggles
    send_ms(8'd0, 0);
    send_ms(8'd255, 1);
    drain();

    // ch0 toggles every word, ch1 clamped duty (zero off phase),
    // ch2 very long on phase, ch3 idle with a full period field
    write_reg(REG_CH0, setting_word(7'd50, 16'd0), 1'b0);
    write_reg(REG_CH1, setting_word(7'd127, 16'd1), 1'b0);
    write_reg(REG_CH2, setting_word(7'd1, 16'hFFFF), 1'b0);
    write_reg(REG_CH3, setting_word(7'd0, 16'hFFFF), 1'b0);
    write_reg(REG_UNUSED, 32'h007F_FFFF, 1'b1);
    foreach (opening_ms[i]) send_ms(opening_ms[i], i % 3);
    drain();

    // inverted on level: stored levels stay put, phases judged afresh
    write_reg(REG_ON_LEVEL, 32'd0, 1'b1);
    send_ms(8'd255, 0);
    send_ms(8'd0, 0);
    send_ms(8'd200, 2);
    drain();
    write_reg(REG_ON_LEVEL, 32'd1, 1'b1);

    for (ph = 0; ph < 10; ph++) begin
      drain();
      for (ch = 0; ch < 4; ch++) begin
        if (ph == 0)
          write_reg(reg_index_e'(int'(REG_CH0) + ch), 32'h007F_FFFF, 1'b0);
        else if (ph == 1)
          write_reg(reg_index_e'(int'(REG_CH0) + ch), 32'd0, 1'b0);
        else
          write_reg(reg_index_e'(int'(REG_CH0) + ch), random_setting(), 1'b0);
      end
      write_reg(REG_ON_LEVEL, (ph == 2) ? 32'd0 : 32'($urandom_range(0, 1)), 1'b1);
      n = (ph < 2) ? 12 : 113;
      for (k = 0; k < n; k++) begin
        if (ph == 3 && k == 20) begin
          hold_asked++;
          while (hold_started != hold_asked) @(posedge clk);
        end
        if (ph == 4 && k == 60)
          drain();
        // phase five and the hold-off burst run without any idling
        if (ph == 5 || (ph == 3 && k >= 20 && k < 50))
          gap = 0;
        else
          gap = pick_gap();
        send_ms(random_ms(), gap);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("covered %0d input words: directed extremes, then ten setting phases",
             sent_words);
    $display("%0d result words checked, %0d channel toggles predicted",
             words_checked, toggles_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("multi_channel_relay_duty_timer_core: match");
    end else begin
      $display("multi_channel_relay_duty_timer_core: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("multi_channel_relay_duty_timer_core: mismatch");
    $finish;
  end

endmodule
